// ----- hw/rtl/quaternion_to_euler_angles_macros.svh -----
// Assertion macros for the quaternion to Euler angle converter
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// clocked property, off while reset is low
`define QTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// value stays within a symmetric range whenever it is marked valid
`define QTE_ASSERT_RANGE(label, clk, rst_n, vld, sig, lim) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld) |-> (($signed(sig) <= $signed(lim)) && ($signed(sig) >= -$signed(lim)))) \
        else $error("angle out of range");

`endif

// ----- hw/rtl/qte_pkg.sv -----
// Shared constants, arctangent table and angle rounding for the converter
`default_nettype none
package qte_pkg;
    localparam int ZW       = 34;
    localparam int TAB_LEN  = 24;
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;

    localparam logic signed [ZW-1:0] DEG90_FINE = 34'sd589824000;
    localparam logic signed [ZW-1:0] ROLL_LIM   = 34'sd18000;
    localparam logic signed [ZW-1:0] PITCH_LIM  = 34'sd9000;
    localparam logic signed [ZW-1:0] HALF_LSB   = 34'sd32768;

    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
        34'sd23437865, 34'sd11730358, 34'sd5866610, 34'sd2933484,
        34'sd1466764, 34'sd733385, 34'sd366693, 34'sd183346,
        34'sd91673, 34'sd45837, 34'sd22918, 34'sd11459,
        34'sd5730, 34'sd2865, 34'sd1432, 34'sd716,
        34'sd358, 34'sd179, 34'sd90, 34'sd45
    };

    // round half up to hundredths of a degree and saturate
    function automatic logic signed [ZW-1:0] to_centi(
        input logic signed [ZW-1:0] fine,
        input logic signed [ZW-1:0] lim
    );
        logic signed [ZW-1:0] v;
        v = (fine + HALF_LSB) >>> 16;
        if (v > lim) begin
            v = lim;
        end
        if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/qte_prep.sv -----
// Product and sum stages: atan2 operands and square root radicands
`default_nettype none
module qte_prep #(
    parameter int B   = 16,
    parameter int S   = 42,
    parameter int SQW = 62
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic signed [B-1:0]   i_w,
    input  wire logic signed [B-1:0]   i_x,
    input  wire logic signed [B-1:0]   i_y,
    input  wire logic signed [B-1:0]   i_z,
    output logic                       o_valid,
    output logic signed [B+3:0]        o_sr,
    output logic signed [B+3:0]        o_cr,
    output logic signed [B+3:0]        o_sy,
    output logic signed [B+3:0]        o_cy,
    output logic        [SQW-1:0]      o_ra,
    output logic        [SQW-1:0]      o_rb
);
    localparam int F  = B - 2;
    localparam int PW = 2 * B;
    localparam int MW = B + 2;
    localparam int SW = B + 4;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< F;

    logic                 r_v1;
    logic signed [PW-1:0] r_pwx, r_pyz, r_pxx, r_pyy, r_pwz, r_pxy, r_pzz, r_pwy, r_pxz;
    logic signed [MW-1:0] m_wx, m_yz, m_xx, m_yy, m_wz, m_xy, m_zz, m_wy, m_xz;
    logic signed [SW-1:0] n_sr, n_cr, n_sy, n_cy, t, ra, rb, ra_c, rb_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_pwx <= i_w * i_x;
        r_pyz <= i_y * i_z;
        r_pxx <= i_x * i_x;
        r_pyy <= i_y * i_y;
        r_pwz <= i_w * i_z;
        r_pxy <= i_x * i_y;
        r_pzz <= i_z * i_z;
        r_pwy <= i_w * i_y;
        r_pxz <= i_x * i_z;
    end

    always_comb begin
        m_wx = MW'(r_pwx >>> F);
        m_yz = MW'(r_pyz >>> F);
        m_xx = MW'(r_pxx >>> F);
        m_yy = MW'(r_pyy >>> F);
        m_wz = MW'(r_pwz >>> F);
        m_xy = MW'(r_pxy >>> F);
        m_zz = MW'(r_pzz >>> F);
        m_wy = MW'(r_pwy >>> F);
        m_xz = MW'(r_pxz >>> F);
        n_sr = (SW'(m_wx) + SW'(m_yz)) <<< 1;
        n_cr = ONE - ((SW'(m_xx) + SW'(m_yy)) <<< 1);
        n_sy = (SW'(m_wz) + SW'(m_xy)) <<< 1;
        n_cy = ONE - ((SW'(m_yy) + SW'(m_zz)) <<< 1);
        t    = SW'(m_wy) - SW'(m_xz);
        ra   = ONE + (t <<< 1);
        rb   = ONE - (t <<< 1);
        ra_c = ra[SW-1] ? '0 : ra;
        rb_c = rb[SW-1] ? '0 : rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_sr <= n_sr;
        o_cr <= n_cr;
        o_sy <= n_sy;
        o_cy <= n_cy;
        o_ra <= {{(SQW-SW){1'b0}}, ra_c} << S;
        o_rb <= {{(SQW-SW){1'b0}}, rb_c} << S;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/qte_sqrt.sv -----
// Pipelined digit-by-digit integer square root, two operands, one root bit per stage
`default_nettype none
module qte_sqrt #(
    parameter int K = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [2*K-1:0]   i_a,
    input  wire logic [2*K-1:0]   i_b,
    output logic                  o_valid,
    output logic [K-1:0]          o_sa,
    output logic [K-1:0]          o_sb
);
    localparam int NW = 2 * K + 1;

    logic          r_v  [0:K-1];
    logic [NW-1:0] r_na [0:K-1];
    logic [NW-1:0] r_ra [0:K-1];
    logic [NW-1:0] r_nb [0:K-1];
    logic [NW-1:0] r_rb [0:K-1];

    for (genvar j = 0; j < K; j++) begin : g_stage
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (K - 1 - j));
        logic          pv;
        logic [NW-1:0] pna, pra, pnb, prb, sa, sb;
        logic [NW-1:0] n_na, n_ra, n_nb, n_rb;

        if (j == 0) begin : g_first
            assign pv  = i_valid;
            assign pna = {1'b0, i_a};
            assign pnb = {1'b0, i_b};
            assign pra = '0;
            assign prb = '0;
        end else begin : g_next
            assign pv  = r_v[j-1];
            assign pna = r_na[j-1];
            assign pnb = r_nb[j-1];
            assign pra = r_ra[j-1];
            assign prb = r_rb[j-1];
        end

        always_comb begin
            sa = pra + BIT;
            sb = prb + BIT;
            if (pna >= sa) begin
                n_na = pna - sa;
                n_ra = (pra >> 1) + BIT;
            end else begin
                n_na = pna;
                n_ra = pra >> 1;
            end
            if (pnb >= sb) begin
                n_nb = pnb - sb;
                n_rb = (prb >> 1) + BIT;
            end else begin
                n_nb = pnb;
                n_rb = prb >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= pv;
            end
            r_na[j] <= n_na;
            r_ra[j] <= n_ra;
            r_nb[j] <= n_nb;
            r_rb[j] <= n_rb;
        end
    end

    assign o_valid = r_v[K-1];
    assign o_sa    = r_ra[K-1][K-1:0];
    assign o_sb    = r_rb[K-1][K-1:0];
endmodule
`default_nettype wire

// ----- hw/rtl/qte_cordic.sv -----
// Pipelined vectoring CORDIC: atan2 in 2^-16 hundredths of a degree
`default_nettype none
module qte_cordic #(
    parameter int IW    = 20,
    parameter int STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [IW-1:0]          i_y,
    input  wire logic signed [IW-1:0]          i_x,
    output logic                               o_valid,
    output logic signed [qte_pkg::ZW-1:0]      o_z
);
    localparam int CW = IW + 2;
    localparam int ZW = qte_pkg::ZW;

    logic                 r_v    [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic signed [CW-1:0] r_x    [0:STEPS];
    logic signed [CW-1:0] r_y    [0:STEPS];
    logic signed [ZW-1:0] r_z    [0:STEPS];

    logic signed [CW-1:0] x0, y0, n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;

    always_comb begin
        x0   = CW'(i_x);
        y0   = CW'(i_y);
        n_x0 = x0;
        n_y0 = y0;
        n_z0 = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_x0 = y0;
                n_y0 = -x0;
                n_z0 = qte_pkg::DEG90_FINE;
            end else begin
                n_x0 = -y0;
                n_y0 = x0;
                n_z0 = -qte_pkg::DEG90_FINE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CW-1:0] dx, dy, n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            if (r_y[i] > 0) begin
                n_x = r_x[i] + dx;
                n_y = r_y[i] - dy;
                n_z = r_z[i] + qte_pkg::ATAN_TAB[i];
            end else begin
                n_x = r_x[i] - dx;
                n_y = r_y[i] + dy;
                n_z = r_z[i] - qte_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            r_zero[i+1] <= r_zero[i];
            r_x[i+1]    <= n_x;
            r_y[i+1]    <= n_y;
            r_z[i+1]    <= n_z;
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_z     = r_zero[STEPS] ? '0 : r_z[STEPS];
endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Top level: quaternion (Q2.14) to roll, pitch and yaw in hundredths of a degree
//
// Fully pipelined: one quaternion per clock, results in order. The square root
// pipeline (one root bit per stage, K root bits) is followed by the CORDIC
// pipeline (one iteration per stage), where K = (COMPONENT_BITS + 4 +
// 2*((58-COMPONENT_BITS)/2))/2. busy is high only during reset. Each result
// shows on the o_ ports for one cycle with o_valid and cannot be held off.
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [COMPONENT_BITS-1:0]     i_quat_w,
    input  wire logic signed [COMPONENT_BITS-1:0]     i_quat_x,
    input  wire logic signed [COMPONENT_BITS-1:0]     i_quat_y,
    input  wire logic signed [COMPONENT_BITS-1:0]     i_quat_z,
    output logic                                      o_valid,
    output logic signed [qte_pkg::ROLL_W-1:0]         o_roll_angle,
    output logic signed [qte_pkg::PITCH_W-1:0]        o_pitch_angle,
    output logic signed [qte_pkg::ROLL_W-1:0]         o_yaw_angle
);
    localparam int B       = COMPONENT_BITS;
    localparam int S       = 2 * ((58 - B) / 2);
    localparam int NW      = B + 3 + S;
    localparam int K       = (NW + 1) / 2;
    localparam int SQW     = 2 * K;
    localparam int SW      = B + 4;
    localparam int ZW      = qte_pkg::ZW;
    localparam int LATENCY = K + CORDIC_STEPS + 4;

    logic                  accept;
    logic                  p_valid, q_valid, c_roll_v, c_pitch_v, c_yaw_v;
    logic signed [SW-1:0]  p_sr, p_cr, p_sy, p_cy;
    logic [SQW-1:0]        p_ra, p_rb;
    logic [K-1:0]          q_sa, q_sb;
    logic signed [SW-1:0]  r_dsr [0:K-1];
    logic signed [SW-1:0]  r_dcr [0:K-1];
    logic signed [SW-1:0]  r_dsy [0:K-1];
    logic signed [SW-1:0]  r_dcy [0:K-1];
    logic signed [ZW-1:0]  z_roll, z_pitch, z_yaw, pitch_fine;
    logic                  n_valid;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    qte_prep #(.B(B), .S(S), .SQW(SQW)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_valid (p_valid),
        .o_sr    (p_sr),
        .o_cr    (p_cr),
        .o_sy    (p_sy),
        .o_cy    (p_cy),
        .o_ra    (p_ra),
        .o_rb    (p_rb)
    );

    qte_sqrt #(.K(K)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_a     (p_ra),
        .i_b     (p_rb),
        .o_valid (q_valid),
        .o_sa    (q_sa),
        .o_sb    (q_sb)
    );

    // hold roll and yaw operands alongside the root pipeline
    always_ff @(posedge i_clk) begin
        r_dsr[0] <= p_sr;
        r_dcr[0] <= p_cr;
        r_dsy[0] <= p_sy;
        r_dcy[0] <= p_cy;
        for (int j = 1; j < K; j++) begin
            r_dsr[j] <= r_dsr[j-1];
            r_dcr[j] <= r_dcr[j-1];
            r_dsy[j] <= r_dsy[j-1];
            r_dcy[j] <= r_dcy[j-1];
        end
    end

    qte_cordic #(.IW(SW), .STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     (r_dsr[K-1]),
        .i_x     (r_dcr[K-1]),
        .o_valid (c_roll_v),
        .o_z     (z_roll)
    );

    qte_cordic #(.IW(K + 1), .STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     ({1'b0, q_sa}),
        .i_x     ({1'b0, q_sb}),
        .o_valid (c_pitch_v),
        .o_z     (z_pitch)
    );

    qte_cordic #(.IW(SW), .STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     (r_dsy[K-1]),
        .i_x     (r_dcy[K-1]),
        .o_valid (c_yaw_v),
        .o_z     (z_yaw)
    );

    assign n_valid    = c_roll_v & c_pitch_v & c_yaw_v;
    assign pitch_fine = (z_pitch <<< 1) - qte_pkg::DEG90_FINE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_valid;
        end
        o_roll_angle  <= qte_pkg::ROLL_W'(qte_pkg::to_centi(z_roll, qte_pkg::ROLL_LIM));
        o_pitch_angle <= qte_pkg::PITCH_W'(qte_pkg::to_centi(pitch_fine, qte_pkg::PITCH_LIM));
        o_yaw_angle   <= qte_pkg::ROLL_W'(qte_pkg::to_centi(z_yaw, qte_pkg::ROLL_LIM));
    end
endmodule
`default_nettype wire

// ----- hw/rtl/qte_checker.sv -----
// Port checker for the quaternion to Euler angle converter, bound to the top level
`default_nettype none
`include "quaternion_to_euler_angles_macros.svh"
module qte_checker #(
    parameter int COMPONENT_BITS = 16,
    parameter int LAT            = 51
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic signed [COMPONENT_BITS-1:0]     i_quat_w,
    input wire logic signed [COMPONENT_BITS-1:0]     i_quat_x,
    input wire logic signed [COMPONENT_BITS-1:0]     i_quat_y,
    input wire logic signed [COMPONENT_BITS-1:0]     i_quat_z,
    input wire logic                                 o_valid,
    input wire logic signed [qte_pkg::ROLL_W-1:0]    o_roll_angle,
    input wire logic signed [qte_pkg::PITCH_W-1:0]   o_pitch_angle,
    input wire logic signed [qte_pkg::ROLL_W-1:0]    o_yaw_angle
);
    `QTE_ASSERT(a_never_busy, i_clk, i_rst_n, !busy, "busy outside reset")
    `QTE_ASSERT(a_valid_from_start, i_clk, i_rst_n, !o_valid || $past(start, LAT), "result without transfer")
    `QTE_ASSERT_RANGE(a_roll_range, i_clk, i_rst_n, o_valid, o_roll_angle, 16'sd18000)
    `QTE_ASSERT_RANGE(a_pitch_range, i_clk, i_rst_n, o_valid, o_pitch_angle, 15'sd9000)
    `QTE_ASSERT_RANGE(a_yaw_range, i_clk, i_rst_n, o_valid, o_yaw_angle, 16'sd18000)
endmodule

bind quaternion_to_euler_angles qte_checker #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .LAT            (LATENCY)
) u_qte_checker (.*);
`default_nettype wire

// ----- sim/quaternion_to_euler_angles_test.sv -----
// Self-checking testbench for the quaternion to roll, pitch and yaw converter
`default_nettype none
module quaternion_to_euler_angles_test;
    localparam int CB = 16;
    localparam int FB = CB - 2;
    localparam int SQ_SH = 2 * ((58 - CB) / 2);
    localparam int STEPS = 16;
    localparam int LATENCY = 51;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint DEG90 = 64'sd589824000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [CB-1:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic o_valid;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;

    t_angles expected_angles[$];
    int mismatches;
    int idle_cycles;
    int send_idle_pct;

    quaternion_to_euler_angles uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .o_valid(o_valid), .o_roll_angle(o_roll_angle),
        .o_pitch_angle(o_pitch_angle), .o_yaw_angle(o_yaw_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shift(a * b, FB);
    endfunction

    function automatic longint atan2_fine(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = DEG90;
            end else begin
                x = -y; y = t; z = -DEG90;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(qte_pkg::ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(qte_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint round_centi(longint fine, longint lim);
        longint v;
        v = floor_shift(fine + 32768, 16);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic t_angles predict_angles(longint w, longint x, longint y, longint z);
        longint one, sr, cr, sy, cy, t, ra, rb, sa, sb;
        t_angles a;
        one = 64'sd1 <<< FB;
        sr = 2 * (qmul(w, x) + qmul(y, z));
        cr = one - 2 * (qmul(x, x) + qmul(y, y));
        sy = 2 * (qmul(w, z) + qmul(x, y));
        cy = one - 2 * (qmul(y, y) + qmul(z, z));
        t = qmul(w, y) - qmul(x, z);
        ra = one + 2 * t;
        rb = one - 2 * t;
        if (ra < 0) ra = 0;
        if (rb < 0) rb = 0;
        sa = int_root(longint'(ra) << SQ_SH);
        sb = int_root(longint'(rb) << SQ_SH);
        a.roll = 16'(round_centi(atan2_fine(sr, cr), 18000));
        a.pitch = 15'(round_centi(2 * atan2_fine(sa, sb) - DEG90, 9000));
        a.yaw = 16'(round_centi(atan2_fine(sy, cy), 18000));
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_quat(logic [CB-1:0] w, logic [CB-1:0] x,
                             logic [CB-1:0] y, logic [CB-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_quat_w <= w; i_quat_x <= x; i_quat_y <= y; i_quat_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_angles.push_back(predict_angles(longint'($signed(w)), longint'($signed(x)),
                                                 longint'($signed(y)), longint'($signed(z))));
        @(negedge i_clk);
    endtask

    task automatic send_random(int n, int shape);
        logic [CB-1:0] v[4];
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 4; j++) begin
                if (shape == 0) begin
                    v[j] = CB'($urandom);
                end else begin
                    v[j] = CB'(int'($urandom_range(32768)) - 16384);
                end
            end
            if (shape == 1 && $urandom_range(3) == 0) begin
                v[$urandom_range(3)] = CB'(int'($urandom_range(16)) - 8);
            end
            send_quat(v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'sd11585, 16'sd11585, 0, 0);
        send_quat(16'sd11585, 0, 16'sd11585, 0);
        send_quat(16'sd11585, 0, 0, 16'sd11585);
        send_quat(16'sd11585, 0, -16'sd11585, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(0, 16'h7fff, 16'h8000, 0);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        send_quat(-16'sd16384, 0, 0, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    endtask

    task automatic test_random_back_to_back();
        send_idle_pct = 0;
        send_random(150, 1);
        send_random(40, 0);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 56;
        send_random(150, 1);
        send_random(40, 0);
    endtask

    task automatic test_random_mixed_idle();
        send_idle_pct = 22;
        send_random(150, 1);
        send_random(40, 0);
        send_idle_pct = 0;
        send_random(150, 1);
    endtask

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_valid) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_angles.pop_front();
                if (o_roll_angle !== e.roll)
                    report_mismatch("roll", o_roll_angle, e.roll);
                if (o_pitch_angle !== e.pitch)
                    report_mismatch("pitch", o_pitch_angle, e.pitch);
                if (o_yaw_angle !== e.yaw)
                    report_mismatch("yaw", o_yaw_angle, e.yaw);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_euler_angles_test NOT OK");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        start = 1'b0;
        i_quat_w = '0; i_quat_x = '0; i_quat_y = '0; i_quat_z = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_back_to_back();
        test_random_sender_idle();
        test_random_mixed_idle();
        start <= 1'b0;
        while (expected_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("quaternion_to_euler_angles_test OK");
        end else begin
            $display("quaternion_to_euler_angles_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_prep.sv
hw/rtl/qte_sqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
hw/rtl/qte_checker.sv
sim/quaternion_to_euler_angles_test.sv
